// File: rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the signed decimal field formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int VAL_W      = 32;
	localparam int WIDTH_W    = 7;
	localparam int PREC_W     = 6;
	localparam int CHAR_W     = 8;
	localparam int MAX_FIELD  = 64;
	localparam int CNT_W      = $clog2(MAX_FIELD + 1);
	localparam int NUM_DIG    = 10;
	localparam int ND_W       = $clog2(NUM_DIG + 1);
	localparam int DIG_IDX_W  = $clog2(NUM_DIG);
	localparam int STEP_W     = $clog2(VAL_W);
	localparam int FIFO_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// one laid-out field, ready to be written out
	typedef struct packed {
		logic                       neg;
		logic                       left;
		logic [CNT_W-1:0]           pad;
		logic [CNT_W-1:0]           zeros;
		logic [ND_W-1:0]            nd;
		logic [NUM_DIG-1:0][3:0]    digits;
	} desc_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PADL,
		B_SIGN,
		B_ZERO,
		B_DIG,
		B_PADR
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

// File: rtl/sdf_fifo.sv
// ----------------------------------------------------------------------------
// sdf_fifo
// Small queue of laid-out fields between the front and the back.
// ----------------------------------------------------------------------------
module sdf_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sdf_pkg::desc_t       wr_data,
	input  logic                 pop,
	output sdf_pkg::desc_t       rd_data,
	output sdf_pkg::fifo_status_t status
);
	import sdf_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	desc_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign rd_data      = mem_q[rd_ptr_q];
	assign status.full  = (fill_q == FILL_W'(FIFO_DEPTH));
	assign status.empty = (fill_q == '0);

endmodule

// File: rtl/sdf_front.sv
// ----------------------------------------------------------------------------
// sdf_front
// Takes an item, converts the magnitude to decimal one bit a cycle
// (shift-and-add-3), then lays out the field and queues it.
// ----------------------------------------------------------------------------
module sdf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [sdf_pkg::VAL_W-1:0]   value,
	input  logic [sdf_pkg::WIDTH_W-1:0]   field_width,
	input  logic [sdf_pkg::PREC_W-1:0]    digit_precision,
	input  logic                          has_precision,
	input  logic                          left_align,
	input  logic                          zero_pad,
	input  sdf_pkg::fifo_status_t         fifo_status,
	output logic                          push,
	output sdf_pkg::desc_t                push_data
);
	import sdf_pkg::*;

	front_state_t             state_q;
	front_state_t             state_d;
	logic [STEP_W-1:0]        step_q;
	logic [VAL_W-1:0]         bin_q;
	logic [NUM_DIG-1:0][3:0]  bcd_q;
	logic [NUM_DIG-1:0][3:0]  bcd_adj;
	logic                     neg_q;
	logic [WIDTH_W-1:0]       width_q;
	logic [PREC_W-1:0]        prec_q;
	logic                     point_q;
	logic                     left_q;
	logic                     zpad_q;
	logic                     accept;

	assign accept = start && (state_q == F_IDLE);

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIG; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q   <= value[VAL_W-1] ? (VAL_W'(0) - VAL_W'(value)) : VAL_W'(value);
			bcd_q   <= '0;
			neg_q   <= value[VAL_W-1];
			width_q <= field_width;
			prec_q  <= digit_precision;
			point_q <= has_precision;
			left_q  <= left_align;
			zpad_q  <= zero_pad;
		end else if (state_q == F_CONV) begin
			bcd_q <= (NUM_DIG*4)'({bcd_adj, bin_q[VAL_W-1]});
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == F_CONV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (start) state_d = F_CONV;
			end
			F_CONV: begin
				if (step_q == STEP_W'(VAL_W - 1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!fifo_status.full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != F_IDLE);
		push = (state_q == F_PUSH) && !fifo_status.full;
	end

	// field layout from the finished digits
	always_comb begin
		logic [ND_W-1:0]    nd;
		logic [WIDTH_W-1:0] prec_lim;
		logic [CNT_W-1:0]   width_sat;
		logic [CNT_W-1:0]   prec_sat;
		logic [CNT_W-1:0]   nd_ext;
		logic [CNT_W-1:0]   sgn;
		logic [CNT_W-1:0]   zeros;
		logic [CNT_W-1:0]   pad;
		logic [CNT_W-1:0]   body;
		nd = ND_W'(1);
		for (int i = 1; i < NUM_DIG; i++) begin
			if (bcd_q[i] != 4'd0) nd = ND_W'(i + 1);
		end
		nd_ext    = CNT_W'(nd);
		sgn       = CNT_W'(neg_q);
		width_sat = (width_q > WIDTH_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(width_q);
		prec_lim  = WIDTH_W'(MAX_FIELD) - WIDTH_W'(neg_q);
		prec_sat  = ({1'b0, prec_q} > prec_lim) ? CNT_W'(prec_lim) : CNT_W'(prec_q);
		zeros     = '0;
		pad       = '0;
		if (point_q) begin
			zeros = (prec_sat > nd_ext) ? prec_sat - nd_ext : '0;
			body  = sgn + zeros + nd_ext;
			pad   = (width_sat > body) ? width_sat - body : '0;
		end else begin
			body = sgn + nd_ext;
			if (width_sat > body) begin
				if (zpad_q && !left_q) zeros = width_sat - body;
				else                   pad   = width_sat - body;
			end
		end
		push_data.neg    = neg_q;
		push_data.left   = left_q;
		push_data.pad    = pad;
		push_data.zeros  = zeros;
		push_data.nd     = nd;
		push_data.digits = bcd_q;
	end

endmodule

// File: rtl/sdf_back.sv
// ----------------------------------------------------------------------------
// sdf_back
// Writes a laid-out field as characters, one per cycle: padding, sign,
// leading zeros, digits, trailing padding.
// ----------------------------------------------------------------------------
module sdf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sdf_pkg::fifo_status_t       fifo_status,
	input  sdf_pkg::desc_t              head,
	output logic                        pop,
	output logic                        out_valid,
	output logic [sdf_pkg::CHAR_W-1:0]  out_char,
	output logic                        last_char
);
	import sdf_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   rem_d;
	desc_t              d_q;
	logic               emit;
	logic               last_d;
	logic [CHAR_W-1:0]  char_d;
	logic [DIG_IDX_W-1:0] dig_idx;
	logic               strobe_q;
	logic               last_q;
	logic [CHAR_W-1:0]  char_q;

	// first non-empty section after the given one
	function automatic back_state_t next_phase(back_state_t cur, desc_t d);
		back_state_t nxt;
		case (cur)
			B_IDLE: begin
				if (!d.left && d.pad != '0) nxt = B_PADL;
				else if (d.neg)             nxt = B_SIGN;
				else if (d.zeros != '0)     nxt = B_ZERO;
				else                        nxt = B_DIG;
			end
			B_PADL: begin
				if (d.neg)              nxt = B_SIGN;
				else if (d.zeros != '0) nxt = B_ZERO;
				else                    nxt = B_DIG;
			end
			B_SIGN:  nxt = (d.zeros != '0) ? B_ZERO : B_DIG;
			B_ZERO:  nxt = B_DIG;
			B_DIG:   nxt = (d.left && d.pad != '0) ? B_PADR : B_IDLE;
			default: nxt = B_IDLE;
		endcase
		return nxt;
	endfunction

	function automatic logic [CNT_W-1:0] phase_len(back_state_t ph, desc_t d);
		logic [CNT_W-1:0] len;
		case (ph)
			B_PADL, B_PADR: len = d.pad;
			B_SIGN:         len = CNT_W'(1);
			B_ZERO:         len = d.zeros;
			B_DIG:          len = CNT_W'(d.nd);
			default:        len = '0;
		endcase
		return len;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		rem_d   = rem_q;
		if (state_q == B_IDLE) begin
			if (!fifo_status.empty) begin
				state_d = next_phase(B_IDLE, head);
				cnt_d   = phase_len(state_d, head);
				rem_d   = head.pad + CNT_W'(head.neg) + head.zeros + CNT_W'(head.nd);
			end
		end else begin
			rem_d = rem_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				state_d = next_phase(state_q, d_q);
				cnt_d   = phase_len(state_d, d_q);
			end else begin
				cnt_d = cnt_q - 1'b1;
			end
		end
	end

	// outputs
	always_comb begin
		pop     = (state_q == B_IDLE) && !fifo_status.empty;
		emit    = (state_q != B_IDLE);
		last_d  = emit && (rem_q == CNT_W'(1));
		dig_idx = DIG_IDX_W'(cnt_q - 1'b1);
		case (state_q)
			B_PADL, B_PADR: char_d = CH_SPACE;
			B_SIGN:         char_d = CH_MINUS;
			B_ZERO:         char_d = CH_ZERO;
			B_DIG:          char_d = CH_ZERO | {4'h0, d_q.digits[dig_idx]};
			default:        char_d = CH_SPACE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			d_q <= head;
		end
		char_q <= char_d;
		last_q <= last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			strobe_q <= emit;
		end
	end

	assign out_valid = strobe_q;
	assign out_char  = char_q;
	assign last_char = last_q;

endmodule

// File: rtl/signed_decimal_field_formatter_core.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_core
// Formats a 32-bit signed value as a printf-style %d field, one character
// per word.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. busy then stays high
// through binary-to-decimal conversion, one bit a cycle, and while the field
// is laid out, longer only while the two-entry queue to the output side is
// full; the next item can be taken as soon as busy is low again. The output
// side writes one character per cycle on out_char with out_valid high for
// that one cycle, last_char marking the final one, and drops out_valid after
// the final character of each field; a queued field reaches out_char through
// the output side's state register and then its output register. A field is
// at most 64 characters wide; conversion overlaps output of earlier fields.
// The output cannot be held off: every word must be taken in its cycle.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [sdf_pkg::VAL_W-1:0]   value,
	input  logic [sdf_pkg::WIDTH_W-1:0]        field_width,
	input  logic [sdf_pkg::PREC_W-1:0]         digit_precision,
	input  logic                               has_precision,
	input  logic                               left_align,
	input  logic                               zero_pad,
	output logic                               out_valid,
	output logic [sdf_pkg::CHAR_W-1:0]         out_char,
	output logic                               last_char
);
	import sdf_pkg::*;

	fifo_status_t fifo_status;
	desc_t        push_data;
	desc_t        head;
	logic         push;
	logic         pop;

	sdf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.field_width     (field_width),
		.digit_precision (digit_precision),
		.has_precision   (has_precision),
		.left_align      (left_align),
		.zero_pad        (zero_pad),
		.fifo_status     (fifo_status),
		.push            (push),
		.push_data       (push_data)
	);

	sdf_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (head),
		.status  (fifo_status)
	);

	sdf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_status (fifo_status),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_char    (out_char),
		.last_char   (last_char)
	);

	// an accepted item keeps the front busy through conversion
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front not busy after accepting an item");

	// the back side rests in the cycle after the last character of a field
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |=> !out_valid)
		else $error("word right after the last character of a field");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == CH_SPACE || out_char == CH_MINUS ||
			(out_char >= CH_ZERO && out_char <= CH_NINE)))
		else $error("character outside space, minus and digits");

	// no pop from an empty queue, no push into a full one
	a_fifo_guard: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && fifo_status.empty) && !(push && fifo_status.full))
		else $error("queue overrun or underrun");

endmodule

// File: bench/signed_decimal_field_formatter_checker.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_checker
// Watches the command and output channels of the field formatter, lays out
// each accepted field in the same way as the block and compares every
// output word against the oldest expected character.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic signed [sdf_pkg::VAL_W-1:0]   value,
	input  logic [sdf_pkg::WIDTH_W-1:0]        field_width,
	input  logic [sdf_pkg::PREC_W-1:0]         digit_precision,
	input  logic                               has_precision,
	input  logic                               left_align,
	input  logic                               zero_pad,
	input  logic                               out_valid,
	input  logic [sdf_pkg::CHAR_W-1:0]         out_char,
	input  logic                               last_char,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 chars_checked,
	output int                                 fields_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import sdf_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} field_char_t;

	field_char_t expected_chars[$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		chars_checked = 0;
		fields_seen   = 0;
	end

	function automatic void push_char(input logic [CHAR_W-1:0] c);
		field_char_t e;
		e.ch   = c;
		e.last = 1'b0;
		expected_chars.push_back(e);
	endfunction

	// lays out one %d field and queues its characters
	function automatic void queue_field(
		input logic [VAL_W-1:0]   raw,
		input logic [WIDTH_W-1:0] w,
		input logic [PREC_W-1:0]  p,
		input logic               hp,
		input logic               la,
		input logic               zp
	);
		logic             neg;
		logic [VAL_W-1:0] mag;
		logic [3:0]       digs [NUM_DIG];
		int unsigned      nd, sgn, wid, prec, zeros, pad, body;
		neg   = raw[VAL_W-1];
		mag   = neg ? (~raw + 1'b1) : raw;
		sgn   = neg ? 1 : 0;
		nd    = 0;
		zeros = 0;
		pad   = 0;
		// zero still yields one digit, most negative value yields ten
		do begin
			digs[nd] = 4'(mag % 10);
			mag      = mag / 10;
			nd++;
		end while (mag != 0 && nd < NUM_DIG);
		wid = (w > MAX_FIELD) ? MAX_FIELD : w;
		if (hp) begin
			prec = p;
			if (prec > MAX_FIELD - sgn)
				prec = MAX_FIELD - sgn;
			zeros = (prec > nd) ? prec - nd : 0;
			body  = sgn + zeros + nd;
			pad   = (wid > body) ? wid - body : 0;
		end else begin
			body = sgn + nd;
			if (wid > body) begin
				if (zp && !la)
					zeros = wid - body;
				else
					pad = wid - body;
			end
		end
		if (!la)
			repeat (pad) push_char(CH_SPACE);
		if (neg)
			push_char(CH_MINUS);
		repeat (zeros) push_char(CH_ZERO);
		for (int i = nd; i > 0; i--)
			push_char(CH_ZERO + 8'(digs[i-1]));
		if (la)
			repeat (pad) push_char(CH_SPACE);
		expected_chars[expected_chars.size()-1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		field_char_t want;
		if (arst_n) begin
			// a word can never belong to a field accepted at the same edge
			if (out_valid) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected word char=%h last=%b",
						out_char, last_char));
				end else begin
					want = expected_chars.pop_front();
					chars_checked++;
					if (want.ch !== out_char || want.last !== last_char)
						report_mismatch($sformatf(
							"char expected %h got %h, last expected %b got %b",
							want.ch, out_char, want.last, last_char));
				end
			end
			if (start && !busy) begin
				queue_field(value, field_width, digit_precision, has_precision,
					left_align, zero_pad);
				fields_seen++;
			end
			pending = expected_chars.size();
		end
	end

endmodule

// File: bench/signed_decimal_field_formatter_core_tb.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_core_tb
// Drives %d field commands into the formatter: a directed set of corner
// fields, then random fields with random gaps between commands. A checker
// beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdf_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 240;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [VAL_W-1:0]   value;
	logic [WIDTH_W-1:0]        field_width;
	logic [PREC_W-1:0]         digit_precision;
	logic                      has_precision;
	logic                      left_align;
	logic                      zero_pad;
	logic                      out_valid;
	logic [CHAR_W-1:0]         out_char;
	logic                      last_char;

	int fail_count;
	int pending;
	int chars_checked;
	int fields_seen;
	int stall_cycles;
	int directed_count;
	bit idle_on;

	signed_decimal_field_formatter_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.field_width     (field_width),
		.digit_precision (digit_precision),
		.has_precision   (has_precision),
		.left_align      (left_align),
		.zero_pad        (zero_pad),
		.out_valid       (out_valid),
		.out_char        (out_char),
		.last_char       (last_char)
	);

	signed_decimal_field_formatter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.field_width     (field_width),
		.digit_precision (digit_precision),
		.has_precision   (has_precision),
		.left_align      (left_align),
		.zero_pad        (zero_pad),
		.out_valid       (out_valid),
		.out_char        (out_char),
		.last_char       (last_char),
		.fail_count      (fail_count),
		.pending         (pending),
		.chars_checked   (chars_checked),
		.fields_seen     (fields_seen)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// nothing accepted on either side for too long ends the run
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || out_valid) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_field(
		input logic [VAL_W-1:0]   v,
		input logic [WIDTH_W-1:0] w,
		input logic [PREC_W-1:0]  p,
		input logic               hp,
		input logic               la,
		input logic               zp
	);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start           <= 1'b1;
		value           <= v;
		field_width     <= w;
		digit_precision <= p;
		has_precision   <= hp;
		left_align      <= la;
		zero_pad        <= zp;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 999);
			1: v = -$urandom_range(1, 99999);
			2: v = $urandom;
			3: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: begin
				// around a power of ten, where the digit count changes
				v = 1;
				repeat ($urandom_range(0, 9)) v = v * 10;
				v = v - $urandom_range(0, 1);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin
		logic [WIDTH_W-1:0] w;
		logic [PREC_W-1:0]  p;
		start           = 1'b0;
		value           = '0;
		field_width     = '0;
		digit_precision = '0;
		has_precision   = 1'b0;
		left_align      = 1'b0;
		zero_pad        = 1'b0;
		idle_on         = 1'b1;
		arst_n          = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner fields
		send_field(32'd0,          7'd0,   6'd0,  1'b0, 1'b0, 1'b0);
		send_field(32'd0,          7'd0,   6'd0,  1'b1, 1'b0, 1'b0);
		send_field(32'd0,          7'd5,   6'd0,  1'b1, 1'b1, 1'b0);
		send_field(-32'sd1,        7'd0,   6'd0,  1'b0, 1'b0, 1'b0);
		send_field(32'd1,          7'd8,   6'd0,  1'b0, 1'b0, 1'b1);
		send_field(32'h7fffffff,   7'd0,   6'd0,  1'b0, 1'b0, 1'b0);
		send_field(32'h80000000,   7'd0,   6'd0,  1'b0, 1'b0, 1'b0);
		send_field(32'h80000000,   7'd15,  6'd0,  1'b0, 1'b0, 1'b1);
		send_field(32'h80000000,   7'd64,  6'd63, 1'b1, 1'b0, 1'b0);
		send_field(32'h7fffffff,   7'd127, 6'd63, 1'b1, 1'b1, 1'b0);
		send_field(-32'sd42,       7'd127, 6'd0,  1'b0, 1'b0, 1'b0);
		send_field(-32'sd42,       7'd64,  6'd0,  1'b0, 1'b1, 1'b0);
		send_field(-32'sd42,       7'd65,  6'd0,  1'b0, 1'b0, 1'b1);
		send_field(-32'sd42,       7'd10,  6'd0,  1'b0, 1'b1, 1'b1);
		send_field(32'd123,        7'd10,  6'd6,  1'b1, 1'b0, 1'b1);
		send_field(-32'sd123,      7'd10,  6'd6,  1'b1, 1'b1, 1'b0);
		send_field(-32'sd123,      7'd3,   6'd2,  1'b1, 1'b0, 1'b0);
		send_field(32'd9,          7'd1,   6'd1,  1'b1, 1'b0, 1'b0);
		send_field(32'd1000000000, 7'd12,  6'd0,  1'b0, 1'b1, 1'b0);
		send_field(-32'sd7,        7'd64,  6'd63, 1'b1, 1'b1, 1'b1);
		send_field(32'd0,          7'd64,  6'd0,  1'b0, 1'b0, 1'b1);
		send_field(32'd55,         7'd4,   6'd0,  1'b0, 1'b0, 1'b0);
		directed_count = 22;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 29) == 0)
				idle_on = !idle_on;
			// mostly short fields, a few reaching the saturation range
			case ($urandom_range(0, 3))
				0, 1: w = WIDTH_W'($urandom_range(0, 20));
				2: w = WIDTH_W'($urandom_range(0, 40));
				default: w = WIDTH_W'($urandom_range(0, 127));
			endcase
			p = ($urandom_range(0, 3) == 0) ? PREC_W'($urandom_range(0, 63)) :
				PREC_W'($urandom_range(0, 14));
			send_field(pick_value(), w, p, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);

		$display("run covered %0d fields (%0d directed), %0d output words compared",
			fields_seen, directed_count, chars_checked);
		$display("widths 0..127, precisions 0..63, all align and pad flag combinations");
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
rtl/sdf_pkg.sv
rtl/sdf_fifo.sv
rtl/sdf_front.sv
rtl/sdf_back.sv
rtl/signed_decimal_field_formatter_core.sv
bench/signed_decimal_field_formatter_checker.sv
bench/signed_decimal_field_formatter_core_tb.sv
